/* hdl/assert_macros.svh */
// Assertion macros shared by the reservation monitor modules.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled while reset is asserted.
`define ASSERT_IMPLIES(lbl, clk, rst_n, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("same-cycle implication failed");

// Next-cycle implication, disabled while reset is asserted.
`define ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("next-cycle implication failed");

`endif

/* hdl/lrm_pkg.sv */
// Types and constants of the load-reserved monitor.
`default_nettype none

package lrm_pkg;

	localparam int NUM_CORES_DEF  = 8;
	localparam int ADDR_WIDTH_DEF = 32;
	localparam int FUNC_W         = 2;
	localparam int CORE_ID_W      = 3;
	localparam int PHYS_ADDR_W    = 32;

	typedef enum logic [FUNC_W-1:0] {
		OP_RESERVE = 2'd0,
		OP_CHECK   = 2'd1,
		OP_ACCESS  = 2'd2,
		OP_CANCEL  = 2'd3
	} op_t;

	typedef enum logic {
		ST_IDLE = 1'b0,
		ST_EXEC = 1'b1
	} state_t;

	typedef struct packed {
		logic load;
		logic exec;
	} cmd_t;

endpackage

`default_nettype wire

/* hdl/load_reserved_monitor_unit.sv */
// Top level of the load-reserved monitor: controller plus slot datapath.
`default_nettype none
`include "assert_macros.svh"

// Reservation monitor for load-reserved / store-conditional atomics, one slot
// per core. A command is taken when start is high and busy is low; busy then
// stays high for the execute state, in which all slots are compared against the
// address in parallel and updated. Every command yields exactly one result beat:
// done pulses for one cycle, registered from the execute state, with
// check_failed valid in that cycle (1 for a failed check, 0 for every other
// operation). No new command is taken while busy is high, but one can be taken
// in the same cycle as done. The receiver cannot stall and must take done when
// it appears.
module load_reserved_monitor_unit #(
	parameter int NUM_CORES  = lrm_pkg::NUM_CORES_DEF,
	parameter int ADDR_WIDTH = lrm_pkg::ADDR_WIDTH_DEF
) (
	input  wire logic                            clk,
	input  wire logic                            arst_n,
	input  wire logic                            start,
	output logic                                 busy,
	input  wire logic [lrm_pkg::FUNC_W-1:0]      func,
	input  wire logic [lrm_pkg::CORE_ID_W-1:0]   core_id,
	input  wire logic [lrm_pkg::PHYS_ADDR_W-1:0] phys_address,
	input  wire logic                            keep_until_cancel,
	output logic                                 done,
	output logic                                 check_failed
);

	lrm_pkg::cmd_t cmd;

	lrm_ctrl u_ctrl (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (start),
		.cmd    (cmd),
		.busy   (busy)
	);

	lrm_datapath #(
		.NUM_CORES  (NUM_CORES),
		.ADDR_WIDTH (ADDR_WIDTH)
	) u_datapath (
		.clk               (clk),
		.arst_n            (arst_n),
		.cmd               (cmd),
		.func              (func),
		.core_id           (core_id),
		.phys_address      (phys_address),
		.keep_until_cancel (keep_until_cancel),
		.done              (done),
		.check_failed      (check_failed)
	);

	`ASSERT_NEXT(a_exec_gives_beat, clk, arst_n, busy, done && !busy)
	`ASSERT_IMPLIES(a_failed_only_on_beat, clk, arst_n, check_failed, done)

endmodule

`default_nettype wire

/* hdl/lrm_ctrl.sv */
// Controller state machine of the load-reserved monitor.
`default_nettype none

module lrm_ctrl (
	input  wire logic         clk,
	input  wire logic         arst_n,
	input  wire logic         start,
	output lrm_pkg::cmd_t     cmd,
	output logic              busy
);

	lrm_pkg::state_t state_q;
	lrm_pkg::state_t state_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= lrm_pkg::ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d  = state_q;
		cmd.load = 1'b0;
		cmd.exec = 1'b0;
		busy     = 1'b0;
		unique case (state_q)
			lrm_pkg::ST_IDLE: begin
				if (start) begin
					cmd.load = 1'b1;
					state_d  = lrm_pkg::ST_EXEC;
				end
			end
			lrm_pkg::ST_EXEC: begin
				cmd.exec = 1'b1;
				busy     = 1'b1;
				state_d  = lrm_pkg::ST_IDLE;
			end
		endcase
	end

endmodule

`default_nettype wire

/* hdl/lrm_datapath.sv */
// Datapath of the load-reserved monitor: command registers and per-core slots.
`default_nettype none
`include "assert_macros.svh"

module lrm_datapath #(
	parameter int NUM_CORES  = lrm_pkg::NUM_CORES_DEF,
	parameter int ADDR_WIDTH = lrm_pkg::ADDR_WIDTH_DEF
) (
	input  wire logic                          clk,
	input  wire logic                          arst_n,
	input  wire lrm_pkg::cmd_t                 cmd,
	input  wire logic [lrm_pkg::FUNC_W-1:0]    func,
	input  wire logic [lrm_pkg::CORE_ID_W-1:0] core_id,
	input  wire logic [lrm_pkg::PHYS_ADDR_W-1:0] phys_address,
	input  wire logic                          keep_until_cancel,
	output logic                               done,
	output logic                               check_failed
);

	lrm_pkg::op_t                  op_q;
	logic [lrm_pkg::CORE_ID_W-1:0] core_q;
	logic [ADDR_WIDTH-1:0]         addr_q;
	logic                          keep_q;

	logic [ADDR_WIDTH-1:0] addr_in;
	logic [NUM_CORES-1:0]  valid_q;
	logic [NUM_CORES-1:0]  manual_q;
	logic [ADDR_WIDTH-1:0] slot_addr_q [NUM_CORES];

	logic [NUM_CORES-1:0] self_v;
	logic [NUM_CORES-1:0] hit_v;
	logic [NUM_CORES-1:0] set_v;
	logic [NUM_CORES-1:0] clr_v;
	logic                 own_hit;

	logic done_q;
	logic check_failed_q;

	generate
		if (ADDR_WIDTH > lrm_pkg::PHYS_ADDR_W) begin : g_addr_ext
			assign addr_in = {{(ADDR_WIDTH-lrm_pkg::PHYS_ADDR_W){1'b0}}, phys_address};
		end else if (ADDR_WIDTH == lrm_pkg::PHYS_ADDR_W) begin : g_addr_eq
			assign addr_in = phys_address;
		end else begin : g_addr_cut
			assign addr_in = phys_address[ADDR_WIDTH-1:0];
		end
	endgenerate

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			op_q   <= lrm_pkg::op_t'(func);
			core_q <= core_id;
			addr_q <= addr_in;
			keep_q <= keep_until_cancel;
		end
	end

	always_comb begin
		for (int i = 0; i < NUM_CORES; i++) begin
			self_v[i] = (int'(core_q) == i);
			hit_v[i]  = valid_q[i] && (slot_addr_q[i] == addr_q);
		end
		own_hit = |(self_v & hit_v);
	end

	always_comb begin
		set_v = '0;
		clr_v = '0;
		unique case (op_q)
			lrm_pkg::OP_RESERVE: set_v = self_v & ~hit_v;
			lrm_pkg::OP_CHECK:   clr_v = '0;
			lrm_pkg::OP_ACCESS:  clr_v = ~self_v & hit_v & ~manual_q;
			lrm_pkg::OP_CANCEL:  clr_v = self_v;
		endcase
		if (!cmd.exec) begin
			set_v = '0;
			clr_v = '0;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q  <= '0;
			manual_q <= '0;
		end else begin
			for (int i = 0; i < NUM_CORES; i++) begin
				if (set_v[i]) begin
					valid_q[i]  <= 1'b1;
					manual_q[i] <= keep_q;
				end else if (clr_v[i]) begin
					valid_q[i]  <= 1'b0;
					manual_q[i] <= 1'b0;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		for (int i = 0; i < NUM_CORES; i++) begin
			if (set_v[i]) begin
				slot_addr_q[i] <= addr_q;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			done_q         <= 1'b0;
			check_failed_q <= 1'b0;
		end else begin
			done_q         <= cmd.exec;
			check_failed_q <= cmd.exec && (op_q == lrm_pkg::OP_CHECK) && !own_hit;
		end
	end

	assign done         = done_q;
	assign check_failed = check_failed_q;

	`ASSERT_NEXT(a_reserve_holds, clk, arst_n, cmd.exec && (op_q == lrm_pkg::OP_RESERVE) && (|self_v), |(self_v & valid_q))
	`ASSERT_NEXT(a_cancel_frees, clk, arst_n, cmd.exec && (op_q == lrm_pkg::OP_CANCEL), !(|(self_v & valid_q)))

endmodule

`default_nettype wire
